// ===== hdl/bta_pkg.sv =====
// Shared types, codes and constants of the boundary-tag allocator.
// No dependencies; every other file refers to it by scoped names.
package bta_pkg;

    localparam int REGION_BYTES_DEF = 1024;

    // field widths
    localparam int KIND_W = 2;
    localparam int OFF_W  = 10;
    localparam int SIZE_W = 11;
    localparam int ST_W   = 2;
    localparam int TAG_W  = 16;

    // signed byte-position arithmetic; covers every address the chain can reach
    localparam int PW = 20;

    localparam int TAG_BYTES        = 4;
    localparam int PAIR_BYTES       = 8;
    localparam int INIT_OVERHEAD    = 13;
    localparam int LAST_FOOTER_BACK = 9;

    // request codes
    localparam logic [KIND_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] REQ_CHECK = 2'd2;
    localparam logic [KIND_W-1:0] REQ_INIT  = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_FREE  = 2'd2;

    typedef logic signed [PW-1:0] pos_t;

    localparam pos_t TAG_P  = pos_t'(TAG_BYTES);
    localparam pos_t PAIR_P = pos_t'(PAIR_BYTES);
    localparam pos_t LFB_P  = pos_t'(LAST_FOOTER_BACK);
    // payload of the initial block relative to the last footer position
    localparam pos_t PAY_BACK_P = pos_t'(INIT_OVERHEAD - LAST_FOOTER_BACK);

    // one tag-store access per cycle; positions outside the store drop writes and read as zero
    typedef struct packed {
        logic             rd;
        logic             wr;
        pos_t             pos;
        logic [TAG_W-1:0] wdata;
    } mem_cmd_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [OFF_W-1:0] offset;
        logic             is_alloc;
    } result_t;

    function automatic pos_t sext_tag(input logic [TAG_W-1:0] t);
        return {{(PW-TAG_W){t[TAG_W-1]}}, t};
    endfunction

endpackage

// ===== hdl/boundary_tag_first_fit_allocator.sv =====
// Boundary-tag first-fit allocator with coalescing over one tag store.
// Instantiates bta_engine and bta_tag_ram; uses bta_pkg.
//
// Usage: one request on the s_ channel (alloc, free, check, init) gives one
// response on the m_ channel, in order. Requests are handled one at a time;
// s_ready is high only while the sequencer is idle.
// Init first sweeps the whole tag store to zero, then writes the header and
// footer of one free block unless no block fits. The walk reads one tag
// at a time through the single RAM port, a read state and then an evaluate
// state per block, so alloc time grows with the number of blocks ahead of
// the first fit.
// Reset: a clearing pass writes zero to all REGION_BYTES tags, one per
// cycle, with s_ready low; the region is empty until an init request.
// The response sits in an output register: a stalled receiver holds it,
// the next request is still taken, and its response waits in the
// sequencer until the output register frees.
module boundary_tag_first_fit_allocator #(
    parameter int REGION_BYTES = bta_pkg::REGION_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bta_pkg::KIND_W-1:0]    s_req_type,
    input  logic [bta_pkg::OFF_W-1:0]     s_block_offset,
    input  logic [bta_pkg::SIZE_W-1:0]    s_request_size,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bta_pkg::ST_W-1:0]      m_status,
    output logic [bta_pkg::OFF_W-1:0]     m_result_offset,
    output logic                          m_is_allocated
);

    bta_pkg::mem_cmd_t         cmd;
    logic [bta_pkg::TAG_W-1:0] rd_tag;
    bta_pkg::result_t          res;
    logic                      res_valid;
    logic                      res_ready;
    logic                      m_valid_reg;
    bta_pkg::result_t          out_reg;

    bta_engine #(
        .REGION_BYTES(REGION_BYTES)
    ) u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_block_offset (s_block_offset),
        .s_request_size (s_request_size),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .cmd            (cmd),
        .rd_tag         (rd_tag)
    );

    bta_tag_ram #(
        .REGION_BYTES(REGION_BYTES)
    ) u_ram (
        .aclk   (aclk),
        .cmd    (cmd),
        .rd_tag (rd_tag)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = out_reg.status;
    assign m_result_offset = out_reg.offset;
    assign m_is_allocated  = out_reg.is_alloc;

endmodule

// ===== hdl/bta_tag_ram.sv =====
// Tag store: single-port synchronous RAM, one access per cycle, registered read.
// Out-of-range positions read as zero and drop writes. Uses bta_pkg.
module bta_tag_ram #(
    parameter int REGION_BYTES = bta_pkg::REGION_BYTES_DEF
) (
    input  logic                          aclk,
    input  bta_pkg::mem_cmd_t             cmd,
    output logic [bta_pkg::TAG_W-1:0]     rd_tag
);

    localparam int AW = $clog2(REGION_BYTES);
    localparam bta_pkg::pos_t DEPTH_P = bta_pkg::pos_t'(REGION_BYTES);

    logic [bta_pkg::TAG_W-1:0] mem [REGION_BYTES];
    logic [bta_pkg::TAG_W-1:0] rdata_reg;
    logic                      oob_reg;
    logic                      in_range;
    logic [AW-1:0]             idx;

    assign in_range = !cmd.pos[bta_pkg::PW-1] && (cmd.pos < DEPTH_P);
    assign idx      = cmd.pos[AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.wr && in_range) begin
            mem[idx] <= cmd.wdata;
        end
        if (cmd.rd) begin
            oob_reg <= !in_range;
            if (in_range) begin
                rdata_reg <= mem[idx];
            end
        end
    end

    assign rd_tag = oob_reg ? '0 : rdata_reg;

endmodule

// ===== hdl/bta_engine.sv =====
// Request sequencer: clearing sweep and init, first-fit walk, split, free with
// coalescing, check. Issues at most one tag-store access per cycle. Uses bta_pkg.
module bta_engine #(
    parameter int REGION_BYTES = bta_pkg::REGION_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bta_pkg::KIND_W-1:0]     s_req_type,
    input  logic [bta_pkg::OFF_W-1:0]      s_block_offset,
    input  logic [bta_pkg::SIZE_W-1:0]     s_request_size,
    output logic                           res_valid,
    input  logic                           res_ready,
    output bta_pkg::result_t               res,
    output bta_pkg::mem_cmd_t              cmd,
    input  logic [bta_pkg::TAG_W-1:0]      rd_tag
);

    localparam int AW = $clog2(REGION_BYTES);
    localparam bta_pkg::pos_t REG_P = bta_pkg::pos_t'(REGION_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(REGION_BYTES - 1);

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_INIT_H = 5'd2;
    localparam logic [4:0] S_INIT_F = 5'd3;
    localparam logic [4:0] S_WALK_RD = 5'd4;
    localparam logic [4:0] S_WALK_EV = 5'd5;
    localparam logic [4:0] S_A_W1   = 5'd6;
    localparam logic [4:0] S_A_W2   = 5'd7;
    localparam logic [4:0] S_A_W3   = 5'd8;
    localparam logic [4:0] S_A_W4   = 5'd9;
    localparam logic [4:0] S_CHK    = 5'd10;
    localparam logic [4:0] S_FREE_T = 5'd11;
    localparam logic [4:0] S_F_W1   = 5'd12;
    localparam logic [4:0] S_F_W2   = 5'd13;
    localparam logic [4:0] S_F_LRD  = 5'd14;
    localparam logic [4:0] S_F_LEV  = 5'd15;
    localparam logic [4:0] S_F_LW1  = 5'd16;
    localparam logic [4:0] S_F_LW2  = 5'd17;
    localparam logic [4:0] S_F_LW3  = 5'd18;
    localparam logic [4:0] S_F_LW4  = 5'd19;
    localparam logic [4:0] S_F_RCHK = 5'd20;
    localparam logic [4:0] S_F_REV  = 5'd21;
    localparam logic [4:0] S_F_RW1  = 5'd22;
    localparam logic [4:0] S_F_RW2  = 5'd23;
    localparam logic [4:0] S_F_RW3  = 5'd24;
    localparam logic [4:0] S_F_RW4  = 5'd25;
    localparam logic [4:0] S_DONE   = 5'd26;

    logic [4:0]       state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             init_reg, init_next;
    bta_pkg::pos_t    end_reg, end_next;
    bta_pkg::pos_t    off_reg, off_next;
    bta_pkg::pos_t    req_reg, req_next;
    bta_pkg::pos_t    cur_reg, cur_next;
    bta_pkg::pos_t    nxt_reg, nxt_next;
    bta_pkg::pos_t    rest_reg, rest_next;
    bta_pkg::pos_t    n_reg, n_next;
    bta_pkg::pos_t    foot_reg, foot_next;
    bta_pkg::pos_t    size_reg, size_next;
    bta_pkg::pos_t    left_reg, left_next;
    bta_pkg::pos_t    right_reg, right_next;
    bta_pkg::pos_t    merged_reg, merged_next;
    bta_pkg::result_t res_reg, res_next;

    bta_pkg::pos_t    tag;
    bta_pkg::pos_t    in_off;
    bta_pkg::pos_t    in_req;
    bta_pkg::pos_t    pay;
    bta_pkg::pos_t    neg_req;

    assign tag     = bta_pkg::sext_tag(rd_tag);
    assign in_off  = $signed({{(bta_pkg::PW-bta_pkg::OFF_W){1'b0}}, s_block_offset});
    assign in_req  = $signed({{(bta_pkg::PW-bta_pkg::SIZE_W){1'b0}}, s_request_size});
    assign pay     = end_reg - bta_pkg::PAY_BACK_P;
    assign neg_req = -req_reg;

    assign s_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        init_next    = init_reg;
        end_next     = end_reg;
        off_next     = off_reg;
        req_next     = req_reg;
        cur_next     = cur_reg;
        nxt_next     = nxt_reg;
        rest_next    = rest_reg;
        n_next       = n_reg;
        foot_next    = foot_reg;
        size_next    = size_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        merged_next  = merged_reg;
        res_next     = res_reg;
        cmd          = '0;

        case (state_reg)
            S_CLEAR: begin
                cmd.wr  = 1'b1;
                cmd.pos = $signed({{(bta_pkg::PW-AW){1'b0}}, clr_cnt_reg});
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST) begin
                    clr_cnt_next = '0;
                    init_next    = 1'b0;
                    if (!init_reg) begin
                        state_next = S_IDLE;
                    end else if (pay >= bta_pkg::pos_t'(1)) begin
                        state_next = S_INIT_H;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    off_next = in_off;
                    req_next = in_req;
                    cur_next = '0;
                    res_next = '0;
                    case (s_req_type)
                        bta_pkg::REQ_INIT: begin
                            end_next   = ((in_req < REG_P) ? in_req : REG_P) - bta_pkg::LFB_P;
                            init_next  = 1'b1;
                            state_next = S_CLEAR;
                        end
                        bta_pkg::REQ_ALLOC: begin
                            state_next = S_WALK_RD;
                        end
                        bta_pkg::REQ_FREE: begin
                            cmd.rd     = 1'b1;
                            cmd.pos    = in_off;
                            state_next = S_FREE_T;
                        end
                        default: begin
                            if (in_off > end_reg) begin
                                state_next = S_DONE;
                            end else begin
                                cmd.rd     = 1'b1;
                                cmd.pos    = in_off;
                                state_next = S_CHK;
                            end
                        end
                    endcase
                end
            end
            S_INIT_H: begin
                cmd.wr     = 1'b1;
                cmd.pos    = '0;
                cmd.wdata  = pay[bta_pkg::TAG_W-1:0];
                state_next = S_INIT_F;
            end
            S_INIT_F: begin
                // footer of the single free block is the last footer
                cmd.wr     = 1'b1;
                cmd.pos    = end_reg;
                cmd.wdata  = pay[bta_pkg::TAG_W-1:0];
                state_next = S_DONE;
            end
            S_WALK_RD: begin
                if (cur_reg > end_reg) begin
                    res_next.status = bta_pkg::ST_NO_SPACE;
                    state_next      = S_DONE;
                end else begin
                    cmd.rd     = 1'b1;
                    cmd.pos    = cur_reg;
                    state_next = S_WALK_EV;
                end
            end
            S_WALK_EV: begin
                if (tag < 0) begin
                    cur_next   = cur_reg - tag + bta_pkg::PAIR_P;
                    state_next = S_WALK_RD;
                end else if (tag > req_reg + bta_pkg::PAIR_P) begin
                    rest_next  = tag - bta_pkg::PAIR_P - req_reg;
                    nxt_next   = cur_reg + req_reg + bta_pkg::PAIR_P;
                    state_next = S_A_W1;
                end else begin
                    // exact fit and zero tags do not fit
                    cur_next   = cur_reg + tag + bta_pkg::PAIR_P;
                    state_next = S_WALK_RD;
                end
            end
            S_A_W1: begin
                cmd.wr     = 1'b1;
                cmd.pos    = nxt_reg;
                cmd.wdata  = rest_reg[bta_pkg::TAG_W-1:0];
                state_next = S_A_W2;
            end
            S_A_W2: begin
                cmd.wr     = 1'b1;
                cmd.pos    = nxt_reg + rest_reg + bta_pkg::TAG_P;
                cmd.wdata  = rest_reg[bta_pkg::TAG_W-1:0];
                state_next = S_A_W3;
            end
            S_A_W3: begin
                cmd.wr     = 1'b1;
                cmd.pos    = cur_reg;
                cmd.wdata  = neg_req[bta_pkg::TAG_W-1:0];
                state_next = S_A_W4;
            end
            S_A_W4: begin
                cmd.wr          = 1'b1;
                cmd.pos         = nxt_reg - bta_pkg::TAG_P;
                cmd.wdata       = neg_req[bta_pkg::TAG_W-1:0];
                res_next.offset = cur_reg[bta_pkg::OFF_W-1:0];
                state_next      = S_DONE;
            end
            S_CHK: begin
                res_next.is_alloc = (tag < 0);
                state_next        = S_DONE;
            end
            S_FREE_T: begin
                if (tag >= 0) begin
                    res_next.status = bta_pkg::ST_NO_FREE;
                    state_next      = S_DONE;
                end else begin
                    n_next     = -tag;
                    foot_next  = off_reg - tag + bta_pkg::TAG_P;
                    state_next = S_F_W1;
                end
            end
            S_F_W1: begin
                cmd.wr     = 1'b1;
                cmd.pos    = off_reg;
                cmd.wdata  = n_reg[bta_pkg::TAG_W-1:0];
                state_next = S_F_W2;
            end
            S_F_W2: begin
                cmd.wr     = 1'b1;
                cmd.pos    = foot_reg;
                cmd.wdata  = n_reg[bta_pkg::TAG_W-1:0];
                size_next  = n_reg;
                state_next = S_F_LRD;
            end
            S_F_LRD: begin
                if (off_reg >= bta_pkg::TAG_P) begin
                    cmd.rd     = 1'b1;
                    cmd.pos    = off_reg - bta_pkg::TAG_P;
                    state_next = S_F_LEV;
                end else begin
                    state_next = S_F_RCHK;
                end
            end
            S_F_LEV: begin
                if (tag > 0) begin
                    left_next  = tag;
                    size_next  = tag + n_reg + bta_pkg::PAIR_P;
                    state_next = S_F_LW1;
                end else begin
                    state_next = S_F_RCHK;
                end
            end
            S_F_LW1: begin
                cmd.wr     = 1'b1;
                cmd.pos    = off_reg - bta_pkg::PAIR_P - left_reg;
                cmd.wdata  = size_reg[bta_pkg::TAG_W-1:0];
                state_next = S_F_LW2;
            end
            S_F_LW2: begin
                cmd.wr     = 1'b1;
                cmd.pos    = foot_reg;
                cmd.wdata  = size_reg[bta_pkg::TAG_W-1:0];
                state_next = S_F_LW3;
            end
            S_F_LW3: begin
                cmd.wr     = 1'b1;
                cmd.pos    = off_reg;
                state_next = S_F_LW4;
            end
            S_F_LW4: begin
                cmd.wr     = 1'b1;
                cmd.pos    = off_reg - bta_pkg::TAG_P;
                state_next = S_F_RCHK;
            end
            S_F_RCHK: begin
                if (foot_reg + bta_pkg::TAG_P <= end_reg) begin
                    cmd.rd     = 1'b1;
                    cmd.pos    = foot_reg + bta_pkg::TAG_P;
                    state_next = S_F_REV;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_F_REV: begin
                if (tag > 0) begin
                    right_next  = tag;
                    merged_next = size_reg + tag + bta_pkg::PAIR_P;
                    state_next  = S_F_RW1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_F_RW1: begin
                cmd.wr     = 1'b1;
                cmd.pos    = foot_reg - size_reg - bta_pkg::TAG_P;
                cmd.wdata  = merged_reg[bta_pkg::TAG_W-1:0];
                state_next = S_F_RW2;
            end
            S_F_RW2: begin
                cmd.wr     = 1'b1;
                cmd.pos    = foot_reg + right_reg + bta_pkg::PAIR_P;
                cmd.wdata  = merged_reg[bta_pkg::TAG_W-1:0];
                state_next = S_F_RW3;
            end
            S_F_RW3: begin
                cmd.wr     = 1'b1;
                cmd.pos    = foot_reg + bta_pkg::TAG_P;
                state_next = S_F_RW4;
            end
            S_F_RW4: begin
                cmd.wr     = 1'b1;
                cmd.pos    = foot_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            init_reg    <= 1'b0;
            end_reg     <= -bta_pkg::LFB_P;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            init_reg    <= init_next;
            end_reg     <= end_next;
        end
        off_reg    <= off_next;
        req_reg    <= req_next;
        cur_reg    <= cur_next;
        nxt_reg    <= nxt_next;
        rest_reg   <= rest_next;
        n_reg      <= n_next;
        foot_reg   <= foot_next;
        size_reg   <= size_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        merged_reg <= merged_next;
        res_reg    <= res_next;
    end

endmodule

// ===== hdl/bta_checker.sv =====
// Port-level checks of the allocator, bound to the top level.
// Uses bta_pkg status codes.
module bta_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [bta_pkg::ST_W-1:0]    m_status,
    input logic [bta_pkg::OFF_W-1:0]   m_result_offset,
    input logic                        m_is_allocated
);

    // reset always starts the clearing sweep, so no request is taken next cycle
    a_reset_busy: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("request taken right after reset");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    // failed requests carry no offset and no check answer
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != bta_pkg::ST_OK |-> m_result_offset == '0 && !m_is_allocated)
        else $error("failed response carries payload");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_result_offset) && $stable(m_is_allocated))
        else $error("stalled response changed");

endmodule

bind boundary_tag_first_fit_allocator bta_checker u_bta_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_result_offset (m_result_offset),
    .m_is_allocated  (m_is_allocated)
);
